/* rtl/akf_pkg.sv */
// Shared types, codes and helpers of the angle Kalman filter.
package akf_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_Q_ANGLE   = 2'd0;
	localparam logic [1:0] REG_Q_BIAS    = 2'd1;
	localparam logic [1:0] REG_R_MEASURE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RND,
		ST_ACC,
		ST_GAIN,
		ST_DIV_INIT,
		ST_DIV_RUN,
		ST_OUT
	} akf_state_t;

	// Multiply-accumulate steps, in the order the sequencer runs them.
	typedef enum logic [3:0] {
		OP_RATE,
		OP_CROSS,
		OP_QANG,
		OP_P11,
		OP_QBIAS,
		OP_K0Y,
		OP_K1Y,
		OP_K1P00,
		OP_K0P00,
		OP_K1P01,
		OP_K0P01
	} akf_op_t;

	// Saturate a 34-bit signed sum to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* rtl/angle_kalman_filter.sv */
// Top level of the angle Kalman filter with its sequencer, multiplier and divider.
//
// Usage: each request on the s_ channel carries one IMU sample (gyro rate, accelerometer
// angle and time step, all fixed point with FRAC_BITS fraction bits). The block predicts
// the angle and a 2x2 covariance, forms two gains by division and corrects the angle and
// gyro bias; the new angle leaves as one request on the m_ channel.
// All arithmetic runs through one shared 33x33 multiplier (eleven steps, each of them a
// multiply, round and accumulate) and one restoring divider that retires one quotient
// bit per cycle and runs twice per sample, once per gain, unless the divisor is zero.
// s_tready is high only while the sequencer is idle, so the block takes no new sample
// before the last one is done. The result sits in an output register; the block takes
// the next sample while it waits, and only stalls at the end of that next sample if the
// old result was still not taken. The noise registers are written through the APB port;
// the user must write them only while the block is idle; the block does not enforce this.
// Reset zeroes the angle, bias, covariance and noise registers and leaves the block idle.
module angle_kalman_filter #(
	parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Sample: gyro_rate [31:0], accel_angle [63:32], time_step [80:64], zero pad above.
	input  logic [87:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Result: angle_out [31:0].
	output logic [31:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import akf_pkg::*;

	// Dividend and quotient width of the gain division.
	localparam int DW    = 32 + FRAC_BITS;
	localparam int CNT_W = $clog2(DW + 1);
	localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic [DW-1:0] POS_LIM = DW'(32'h7FFF_FFFF);
	localparam logic [DW-1:0] NEG_LIM = DW'(33'h1_0000_0000) >> 1;

	akf_state_t state_q, state_d;
	akf_op_t    op_q;

	// Configuration registers.
	logic [30:0] q_angle_q, q_bias_q, r_measure_q;

	// Filter state and per-sample working registers.
	logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] meas_q, aux_q, y_q, s_q, k0_q, k1_q, fx_q;
	logic signed [32:0] tmp_q;
	logic [16:0]        dt_q;
	logic signed [65:0] prod_q;

	// Divider.
	logic [31:0]      rem_q, dmag_q;
	logic [DW-1:0]    dq_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q, sel_q;

	logic [31:0] out_q;
	logic        out_valid_q;

	// APB: always ready, register i at byte address 4*i.
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_Q_ANGLE:   prdata = {1'b0, q_angle_q};
			REG_Q_BIAS:    prdata = {1'b0, q_bias_q};
			REG_R_MEASURE: prdata = {1'b0, r_measure_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q   <= '0;
			q_bias_q    <= '0;
			r_measure_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_Q_ANGLE:   q_angle_q   <= pwdata[30:0];
				REG_Q_BIAS:    q_bias_q    <= pwdata[30:0];
				REG_R_MEASURE: r_measure_q <= pwdata[30:0];
				default:       ;
			endcase
		end
	end

	// Shared multiplier operand selection.
	logic signed [32:0] mul_a, mul_b;
	always_comb begin
		mul_a = $signed({16'd0, dt_q});
		mul_b = 33'(aux_q);
		unique case (op_q)
			OP_RATE:  begin mul_a = $signed({16'd0, dt_q}); mul_b = 33'(aux_q); end
			OP_CROSS: begin mul_a = $signed({16'd0, dt_q}); mul_b = 33'(aux_q); end
			OP_QANG:  begin mul_a = $signed({16'd0, dt_q}); mul_b = $signed({2'b0, q_angle_q}); end
			OP_P11:   begin mul_a = $signed({16'd0, dt_q}); mul_b = 33'(p11_q); end
			OP_QBIAS: begin mul_a = $signed({16'd0, dt_q}); mul_b = $signed({2'b0, q_bias_q}); end
			OP_K0Y:   begin mul_a = 33'(k0_q); mul_b = 33'(y_q); end
			OP_K1Y:   begin mul_a = 33'(k1_q); mul_b = 33'(y_q); end
			OP_K1P00: begin mul_a = 33'(k1_q); mul_b = 33'(p00_q); end
			OP_K0P00: begin mul_a = 33'(k0_q); mul_b = 33'(p00_q); end
			OP_K1P01: begin mul_a = 33'(k1_q); mul_b = 33'(p01_q); end
			OP_K0P01: begin mul_a = 33'(k0_q); mul_b = 33'(p01_q); end
			default:  ;
		endcase
	end

	// Round to nearest (ties up) and saturate the registered product.
	logic signed [65:0] rnd_sh;
	logic signed [31:0] rnd_sat;
	always_comb begin
		rnd_sh = (prod_q + HALF) >>> FRAC_BITS;
		if (rnd_sh > 66'sh0_7FFF_FFFF) begin
			rnd_sat = 32'sh7FFF_FFFF;
		end else if (rnd_sh < -66'sh0_8000_0000) begin
			rnd_sat = 32'sh8000_0000;
		end else begin
			rnd_sat = rnd_sh[31:0];
		end
	end

	// Divider step and operand magnitudes.
	logic signed [31:0] div_num;
	logic [31:0]        num_mag, den_mag;
	logic [32:0]        trial;
	logic               take;
	logic [DW-1:0]      qmag;
	logic signed [31:0] quo_sat;
	always_comb begin
		div_num = sel_q ? p10_q : p00_q;
		num_mag = div_num[31] ? 32'(-div_num) : div_num;
		den_mag = s_q[31] ? 32'(-s_q) : s_q;
		trial   = {rem_q, dq_q[DW-1]};
		take    = trial >= {1'b0, dmag_q};
		qmag    = dq_q;
		if (neg_q) begin
			quo_sat = (qmag > NEG_LIM) ? 32'sh8000_0000 : 32'(-qmag[31:0]);
		end else begin
			quo_sat = (qmag > POS_LIM) ? 32'sh7FFF_FFFF : qmag[31:0];
		end
	end

	logic in_acc, out_free;
	assign in_acc   = s_tvalid & s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_RND;
			ST_RND: state_d = ST_ACC;
			ST_ACC: begin
				if (op_q == OP_QBIAS) state_d = ST_GAIN;
				else if (op_q == OP_K0P01) state_d = ST_OUT;
				else state_d = ST_MUL;
			end
			ST_GAIN: state_d = ST_DIV_INIT;
			ST_DIV_INIT: begin
				if (s_q != 0) state_d = ST_DIV_RUN;
				else if (sel_q) state_d = ST_MUL;
			end
			ST_DIV_RUN: begin
				if (cnt_q == 0) state_d = sel_q ? ST_MUL : ST_DIV_INIT;
			end
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath and filter state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_RATE;
			sel_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			ang_q       <= '0;
			bias_q      <= '0;
			p00_q       <= '0;
			p01_q       <= '0;
			p10_q       <= '0;
			p11_q       <= '0;
		end else begin
			// A new result replaces the old one in the same cycle it is taken.
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						aux_q  <= sat32(34'($signed(s_tdata[31:0])) - 34'(bias_q));
						meas_q <= s_tdata[63:32];
						dt_q   <= s_tdata[80:64];
						op_q   <= OP_RATE;
					end
				end
				ST_MUL: prod_q <= mul_a * mul_b;
				ST_RND: fx_q <= rnd_sat;
				ST_ACC: begin
					unique case (op_q)
						OP_RATE: begin
							ang_q <= sat32(34'(ang_q) + 34'(fx_q));
							aux_q <= sat32(34'(p10_q) + 34'(p01_q));
						end
						OP_CROSS: tmp_q <= 33'(p00_q) - 33'(fx_q);
						OP_QANG:  p00_q <= sat32(34'(tmp_q) + 34'(fx_q));
						OP_P11: begin
							p01_q <= sat32(34'(p01_q) - 34'(fx_q));
							p10_q <= sat32(34'(p10_q) - 34'(fx_q));
						end
						OP_QBIAS: p11_q  <= sat32(34'(p11_q) + 34'(fx_q));
						OP_K0Y:   ang_q  <= sat32(34'(ang_q) + 34'(fx_q));
						OP_K1Y:   bias_q <= sat32(34'(bias_q) + 34'(fx_q));
						OP_K1P00: p10_q  <= sat32(34'(p10_q) - 34'(fx_q));
						OP_K0P00: p00_q  <= sat32(34'(p00_q) - 34'(fx_q));
						OP_K1P01: p11_q  <= sat32(34'(p11_q) - 34'(fx_q));
						OP_K0P01: p01_q  <= sat32(34'(p01_q) - 34'(fx_q));
						default: ;
					endcase
					if (op_q != OP_QBIAS && op_q != OP_K0P01) op_q <= akf_op_t'(op_q + 4'd1);
				end
				ST_GAIN: begin
					y_q   <= sat32(34'(meas_q) - 34'(ang_q));
					s_q   <= sat32(34'(p00_q) + $signed({3'b0, r_measure_q}));
					sel_q <= 1'b0;
				end
				ST_DIV_INIT: begin
					if (s_q == 0) begin
						// A zero divisor gives zero gain.
						if (sel_q) begin
							k1_q <= '0;
							op_q <= OP_K0Y;
						end else begin
							k0_q  <= '0;
							sel_q <= 1'b1;
						end
					end else begin
						rem_q  <= '0;
						dmag_q <= den_mag;
						dq_q   <= {num_mag, FRAC_BITS'(0)};
						neg_q  <= div_num[31] ^ s_q[31];
						cnt_q  <= CNT_W'(DW);
					end
				end
				ST_DIV_RUN: begin
					if (cnt_q != 0) begin
						rem_q <= take ? 32'(trial - {1'b0, dmag_q}) : trial[31:0];
						dq_q  <= {dq_q[DW-2:0], take};
						cnt_q <= cnt_q - 1'b1;
					end else if (sel_q) begin
						k1_q <= quo_sat;
						op_q <= OP_K0Y;
					end else begin
						k0_q  <= quo_sat;
						sel_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_q <= ang_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tdata  = out_q;
	assign m_tvalid = out_valid_q;

`ifndef ASSERT_OFF
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_MUL && op_q == OP_RATE))
		else $error("sample did not start at the first step");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output state");
	a_gain_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GAIN) |-> $past(state_q == ST_ACC && op_q == OP_QBIAS))
		else $error("gain step entered out of order");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_RUN) |-> (s_q != 0 && dmag_q != 0))
		else $error("divider running on a zero divisor");
`endif

endmodule
